FILE: rtl/lwpc_pkg.sv
// Shared codes and types for the LRU write-back page cache directory.
`default_nettype none
package lwpc_pkg;
    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_MARK  = 3'd2;
    localparam logic [2:0] ACT_FLUSH = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_WB      = 3'd4;
    localparam logic [2:0] ST_NODIRTY = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_WALK
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/lwpc_match.sv
// Shared compare unit: parallel tag match, rank match and free-slot search.
`default_nettype none
module lwpc_match #(
    parameter int N  = 16,
    parameter int PB = 24,
    parameter int RW = 4
) (
    input  wire logic          i_valid [N],
    input  wire logic [PB-1:0] i_tag   [N],
    input  wire logic [RW-1:0] i_rank  [N],
    input  wire logic [PB-1:0] i_key_tag,
    input  wire logic [RW-1:0] i_key_rank,
    output logic [N-1:0]       o_tag_hit,
    output logic [N-1:0]       o_rank_hit,
    output logic               o_hit_any,
    output logic [RW-1:0]      o_hit_idx,
    output logic               o_rank_any,
    output logic [RW-1:0]      o_rank_idx,
    output logic [RW-1:0]      o_free_idx
);
    always_comb begin
        o_hit_idx  = '0;
        o_rank_idx = '0;
        o_free_idx = '0;
        for (int i = 0; i < N; i++) begin
            o_tag_hit[i]  = i_valid[i] && (i_tag[i] == i_key_tag);
            o_rank_hit[i] = i_valid[i] && (i_rank[i] == i_key_rank);
        end
        // Scan from the top so the lowest matching index wins.
        for (int i = N - 1; i >= 0; i--) begin
            if (o_tag_hit[i]) o_hit_idx = RW'(i);
            if (o_rank_hit[i]) o_rank_idx = RW'(i);
            if (!i_valid[i]) o_free_idx = RW'(i);
        end
        o_hit_any  = |o_tag_hit;
        o_rank_any = |o_rank_hit;
    end
endmodule
`default_nettype wire

FILE: rtl/lru_writeback_page_cache.sv
// Top level of the LRU write-back page cache directory.
`default_nettype none
// A request is taken when start is high and busy is low. Requests other
// than flush and clear hold busy only for the lookup cycle. In that
// cycle the shared compare unit does all the tag and rank compares in
// parallel and the whole lookup and update. Their single result is on the
// outputs in the cycle after the lookup cycle. A new request can be
// accepted while that result is on the outputs. Flush and clear walk the
// recency order one rank per cycle through that same compare unit, and
// write-back results come out at most one per cycle. Each result sits on
// the outputs for exactly one cycle with o_strobe high, and the receiver
// cannot stall it; o_last marks the final result of each request.
module lru_writeback_page_cache #(
    parameter int CACHE_ENTRIES = 16,
    parameter int PAGE_ID_BITS  = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              i_action,
    input  wire logic signed [PAGE_ID_BITS:0] i_page_id,
    output logic                         o_strobe,
    output logic [2:0]                   o_status,
    output logic                         o_fetch_needed,
    output logic                         o_evict_valid,
    output logic [PAGE_ID_BITS-1:0]      o_evict_page,
    output logic                         o_evict_writeback,
    output logic [PAGE_ID_BITS-1:0]      o_writeback_page,
    output logic                         o_last
);
    import lwpc_pkg::*;

    localparam int N  = CACHE_ENTRIES;
    localparam int PB = PAGE_ID_BITS;
    localparam int RW = $clog2(N);
    localparam int OW = $clog2(N + 1);

    t_state r_state, n_state;

    logic [PB-1:0] r_tag   [N];
    logic          r_valid [N];
    logic          r_dirty [N];
    logic [RW-1:0] r_rank  [N];
    logic [OW-1:0] r_occ;
    logic [OW-1:0] r_walk;
    logic [2:0]    r_act;
    logic [PB:0]   r_page;
    logic          r_pend;
    logic [PB-1:0] r_pend_page;

    logic          r_strobe, r_fetch, r_ev, r_evwb, r_last;
    logic [2:0]    r_status;
    logic [PB-1:0] r_evpage, r_wbpage;

    logic [N-1:0]  tag_hit, rank_hit;
    logic          hit_any, rank_any;
    logic [RW-1:0] hit_idx, rank_idx, free_idx, key_rank, ins_slot;
    logic          accept, neg, full, is_rw, walk_done;

    assign accept    = start && (r_state == S_IDLE);
    assign neg       = r_page[PB];
    assign full      = (r_occ >= OW'(N));
    assign is_rw     = (r_act == ACT_READ) || (r_act == ACT_WRITE);
    assign walk_done = (r_walk >= r_occ);
    // The eviction victim is the least recent rank; the walk steps ranks.
    assign key_rank  = (r_state == S_WALK) ? r_walk[RW-1:0] : RW'(N - 1);
    assign ins_slot  = full ? rank_idx : free_idx;

    lwpc_match #(.N(N), .PB(PB), .RW(RW)) u_match (
        .i_valid    (r_valid),
        .i_tag      (r_tag),
        .i_rank     (r_rank),
        .i_key_tag  (r_page[PB-1:0]),
        .i_key_rank (key_rank),
        .o_tag_hit  (tag_hit),
        .o_rank_hit (rank_hit),
        .o_hit_any  (hit_any),
        .o_hit_idx  (hit_idx),
        .o_rank_any (rank_any),
        .o_rank_idx (rank_idx),
        .o_free_idx (free_idx)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = ((i_action == ACT_FLUSH) || (i_action == ACT_CLEAR))
                              ? S_WALK : S_LOOK;
                end
            end
            S_LOOK: n_state = S_IDLE;
            S_WALK: begin
                if (walk_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tag store: written only on a miss insertion.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK && is_rw && !neg && !hit_any) begin
            r_tag[ins_slot] <= r_page[PB-1:0];
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_page <= i_page_id;
        end
        r_fetch  <= 1'b0;
        r_ev     <= 1'b0;
        r_evpage <= '0;
        r_evwb   <= 1'b0;
        r_wbpage <= '0;
        r_last   <= 1'b1;
        r_status <= ST_REJECT;
        if (r_state == S_LOOK) begin
            case (r_act) inside
                ACT_READ, ACT_WRITE: begin
                    if (!neg && hit_any) begin
                        r_status <= ST_HIT;
                    end else if (!neg) begin
                        r_status <= ST_MISS;
                        r_fetch  <= (r_act == ACT_READ);
                        if (full && rank_any) begin
                            r_ev     <= 1'b1;
                            r_evpage <= r_tag[rank_idx];
                            r_evwb   <= r_dirty[rank_idx];
                        end
                    end
                end
                ACT_MARK: r_status <= (!neg && hit_any) ? ST_HIT : ST_ABSENT;
                default:  r_status <= ST_REJECT;
            endcase
        end else if (r_state == S_WALK) begin
            if (walk_done) begin
                r_status <= r_pend ? ST_WB : ST_NODIRTY;
                r_wbpage <= r_pend ? r_pend_page : '0;
            end else begin
                r_status <= ST_WB;
                r_wbpage <= r_pend_page;
                r_last   <= 1'b0;
            end
        end
        if (r_state == S_WALK && !walk_done && rank_any && r_dirty[rank_idx]) begin
            r_pend_page <= r_tag[rank_idx];
        end
    end

    // Directory state and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_valid[i] <= 1'b0;
                r_dirty[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
            r_occ    <= '0;
            r_walk   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (accept) begin
                r_walk <= '0;
                r_pend <= 1'b0;
            end
            if (r_state == S_LOOK) begin
                r_strobe <= 1'b1;
                if (is_rw && !neg && hit_any) begin
                    for (int i = 0; i < N; i++) begin
                        if (r_valid[i] && r_rank[i] < r_rank[hit_idx]) begin
                            r_rank[i] <= r_rank[i] + 1'b1;
                        end
                    end
                    r_rank[hit_idx] <= '0;
                    if (r_act == ACT_WRITE) r_dirty[hit_idx] <= 1'b1;
                end else if (is_rw && !neg) begin
                    for (int i = 0; i < N; i++) begin
                        if (r_valid[i]) r_rank[i] <= r_rank[i] + 1'b1;
                    end
                    r_rank[ins_slot]  <= '0;
                    r_valid[ins_slot] <= 1'b1;
                    r_dirty[ins_slot] <= (r_act == ACT_WRITE);
                    if (!full) r_occ <= r_occ + 1'b1;
                end else if (r_act == ACT_MARK && !neg && hit_any) begin
                    r_dirty[hit_idx] <= 1'b1;
                end
            end else if (r_state == S_WALK) begin
                if (walk_done) begin
                    r_strobe <= 1'b1;
                    if (r_act == ACT_CLEAR) begin
                        for (int i = 0; i < N; i++) begin
                            r_valid[i] <= 1'b0;
                            r_dirty[i] <= 1'b0;
                            r_rank[i]  <= '0;
                        end
                        r_occ <= '0;
                    end
                end else begin
                    r_walk <= r_walk + 1'b1;
                    if (rank_any && r_dirty[rank_idx]) begin
                        // A newly found dirty entry releases the held one.
                        r_strobe          <= r_pend;
                        r_pend            <= 1'b1;
                        r_dirty[rank_idx] <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_fetch_needed    = r_fetch;
    assign o_evict_valid     = r_ev;
    assign o_evict_page      = r_evpage;
    assign o_evict_writeback = r_evwb;
    assign o_writeback_page  = r_wbpage;
    assign o_last            = r_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(N)) else $error("occupancy above capacity");
    a_tag_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tag_hit)) else $error("page present in two entries");
    a_rank_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(rank_hit)) else $error("recency rank shared by two entries");
    a_lookup_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_READ || i_action == ACT_MARK))
        |=> ##1 (o_strobe && o_last)) else $error("lookup result missing");
endmodule
`default_nettype wire

FILE: tb/sv/lru_writeback_page_cache_test.sv
// Self-checking testbench for the LRU write-back page cache directory.
`timescale 1ns / 1ps
module lru_writeback_page_cache_test;
    import lwpc_pkg::*;

    localparam int ENTRIES = 16;
    localparam int PBITS = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_REQUESTS = 180;

    // One result as the block presents it.
    typedef struct packed {
        logic [2:0]       status;
        logic             fetch;
        logic             ev_valid;
        logic [PBITS-1:0] ev_page;
        logic             ev_wb;
        logic [PBITS-1:0] wb_page;
        logic             last;
    } t_result;

    // One row of the directed table. When has_result is set, the first
    // result of the request must also equal known_result.
    typedef struct {
        logic [2:0]       action;
        logic [PBITS:0]   page;
        bit               has_result;
        t_result          known_result;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_action = ACT_READ;
    logic signed [PBITS:0] i_page_id = '0;
    logic o_strobe;
    logic [2:0] o_status;
    logic o_fetch_needed;
    logic o_evict_valid;
    logic [PBITS-1:0] o_evict_page;
    logic o_evict_writeback;
    logic [PBITS-1:0] o_writeback_page;
    logic o_last;

    lru_writeback_page_cache #(
        .CACHE_ENTRIES(ENTRIES),
        .PAGE_ID_BITS(PBITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_page_id(i_page_id),
        .o_strobe(o_strobe),
        .o_status(o_status),
        .o_fetch_needed(o_fetch_needed),
        .o_evict_valid(o_evict_valid),
        .o_evict_page(o_evict_page),
        .o_evict_writeback(o_evict_writeback),
        .o_writeback_page(o_writeback_page),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // The predictor's own copy of the directory.
    logic [PBITS-1:0] dir_tag [ENTRIES];
    bit               dir_valid [ENTRIES];
    bit               dir_dirty [ENTRIES];
    int               dir_rank [ENTRIES];
    int               dir_count;

    t_result pending_results[$];
    int      fail_count = 0;
    int      idle_cycles = 0;

    function automatic t_result make_result(logic [2:0] status, logic fetch = 0,
                                            logic evv = 0, logic [PBITS-1:0] evp = 0,
                                            logic evw = 0, logic [PBITS-1:0] wbp = 0,
                                            logic last = 1);
        t_result r;
        r.status = status;
        r.fetch = fetch;
        r.ev_valid = evv;
        r.ev_page = evp;
        r.ev_wb = evw;
        r.wb_page = wbp;
        r.last = last;
        return r;
    endfunction

    // Appends one expected result to the end of the queue.
    task automatic expect_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic empty_directory();
        for (int i = 0; i < ENTRIES; i++) begin
            dir_tag[i] = '0;
            dir_valid[i] = 0;
            dir_dirty[i] = 0;
            dir_rank[i] = 0;
        end
        dir_count = 0;
    endtask

    function automatic int lookup_page(logic [PBITS-1:0] tag);
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && dir_tag[i] == tag)
                return i;
        return -1;
    endfunction

    // Writes back every dirty entry from most to least recent and cleans it.
    task automatic queue_writebacks();
        int total;
        int n;
        total = 0;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && dir_dirty[i])
                total++;
        for (int r = 0; r < dir_count; r++)
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i] && dir_rank[i] == r && dir_dirty[i]) begin
                    n++;
                    expect_result(make_result(ST_WB, 0, 0, 0, 0,
                                              dir_tag[i], n == total));
                    dir_dirty[i] = 0;
                end
        if (total == 0)
            expect_result(make_result(ST_NODIRTY));
    endtask

    // Computes the results of one accepted request and updates the directory.
    task automatic predict_directory(logic [2:0] action, logic [PBITS:0] page);
        bit neg;
        logic [PBITS-1:0] tag;
        int e;
        int victim;
        logic evv;
        logic evw;
        logic [PBITS-1:0] evp;
        int old_rank;
        neg = page[PBITS];
        tag = page[PBITS-1:0];
        evv = 0;
        evw = 0;
        evp = '0;
        if (action == ACT_READ || action == ACT_WRITE) begin
            if (neg) begin
                expect_result(make_result(ST_REJECT));
                return;
            end
            e = lookup_page(tag);
            if (e >= 0) begin
                old_rank = dir_rank[e];
                for (int i = 0; i < ENTRIES; i++)
                    if (dir_valid[i] && dir_rank[i] < old_rank)
                        dir_rank[i]++;
                dir_rank[e] = 0;
                if (action == ACT_WRITE)
                    dir_dirty[e] = 1;
                expect_result(make_result(ST_HIT));
                return;
            end
            if (dir_count >= ENTRIES) begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (victim < 0 && dir_valid[i] && dir_rank[i] == dir_count - 1)
                        victim = i;
                if (victim >= 0) begin
                    evv = 1;
                    evp = dir_tag[victim];
                    evw = dir_dirty[victim];
                    dir_valid[victim] = 0;
                    dir_dirty[victim] = 0;
                    dir_rank[victim] = 0;
                    dir_count--;
                end
            end
            e = 0;
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (!dir_valid[i])
                    e = i;
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i])
                    dir_rank[i]++;
            dir_valid[e] = 1;
            dir_dirty[e] = (action == ACT_WRITE);
            dir_tag[e] = tag;
            dir_rank[e] = 0;
            dir_count++;
            expect_result(make_result(ST_MISS, action == ACT_READ,
                                      evv, evp, evw));
        end else if (action == ACT_MARK) begin
            e = neg ? -1 : lookup_page(tag);
            if (e < 0) begin
                expect_result(make_result(ST_ABSENT));
            end else begin
                dir_dirty[e] = 1;
                expect_result(make_result(ST_HIT));
            end
        end else if (action == ACT_FLUSH) begin
            queue_writebacks();
        end else if (action == ACT_CLEAR) begin
            queue_writebacks();
            empty_directory();
        end else begin
            expect_result(make_result(ST_REJECT));
        end
    endtask

    // Drives one request from the falling edge and waits until it is taken.
    task automatic issue_request(logic [2:0] action, logic [PBITS:0] page);
        i_action <= action;
        i_page_id <= page;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_directory(action, page);
        @(negedge i_clk);
    endtask

    // The sender idles between bursts; start drops only here.
    task automatic sender_gap(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Result checker: every strobed result is matched against the oldest one
    // that the predictor queued.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_strobe) begin
            got = {o_status, o_fetch_needed, o_evict_valid, o_evict_page,
                   o_evict_writeback, o_writeback_page, o_last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    fail_count++;
                end
                if (got.fetch !== want.fetch) begin
                    $display("%0t: fetch_needed expected %0d actual %0d", $time,
                             want.fetch, got.fetch);
                    fail_count++;
                end
                if (got.ev_valid !== want.ev_valid) begin
                    $display("%0t: evict_valid expected %0d actual %0d", $time,
                             want.ev_valid, got.ev_valid);
                    fail_count++;
                end
                if (got.ev_page !== want.ev_page) begin
                    $display("%0t: evict_page expected %h actual %h", $time,
                             want.ev_page, got.ev_page);
                    fail_count++;
                end
                if (got.ev_wb !== want.ev_wb) begin
                    $display("%0t: evict_writeback expected %0d actual %0d", $time,
                             want.ev_wb, got.ev_wb);
                    fail_count++;
                end
                if (got.wb_page !== want.wb_page) begin
                    $display("%0t: writeback_page expected %h actual %h", $time,
                             want.wb_page, got.wb_page);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lru_writeback_page_cache_test NOT OK");
            $finish;
        end
    end

    // Random page: mostly a small pool so hits, evictions and dirty entries
    // are common, sometimes an extreme or negative value.
    function automatic logic [PBITS:0] random_page();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return (PBITS+1)'($urandom_range(0, 23)) | ((pick < 10) ? 25'h0FFFF00 : 25'h0);
        else if (pick < 85)
            return {1'b0, PBITS'($urandom)};
        else if (pick < 90)
            return {1'b0, {PBITS{1'b1}}};
        else
            return {1'b1, PBITS'($urandom)};
    endfunction

    function automatic logic [2:0] random_action();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return ACT_READ;
        if (pick < 72) return ACT_WRITE;
        if (pick < 86) return ACT_MARK;
        if (pick < 93) return ACT_FLUSH;
        if (pick < 97) return ACT_CLEAR;
        return 3'($urandom_range(5, 7));
    endfunction

    t_row directed[$];

    initial begin
        int burst;
        logic [2:0] act;
        // Directed table. Known results are typed in where obvious; the
        // predictor checks every row either way.
        directed = '{
            '{ACT_FLUSH, 25'd0,        1, make_result(ST_NODIRTY)},
            '{ACT_MARK,  25'd5,        1, make_result(ST_ABSENT)},
            '{ACT_READ,  25'h1FFFFFF,  1, make_result(ST_REJECT)},
            '{ACT_WRITE, 25'h1000000,  1, make_result(ST_REJECT)},
            '{ACT_MARK,  25'h1FFFFFF,  1, make_result(ST_ABSENT)},
            '{3'd5,      25'd1,        1, make_result(ST_REJECT)},
            '{3'd6,      25'd1,        1, make_result(ST_REJECT)},
            '{3'd7,      25'h1FFFFFF,  1, make_result(ST_REJECT)},
            '{ACT_READ,  25'd0,        1, make_result(ST_MISS, 1)},
            '{ACT_WRITE, 25'h0FFFFFF,  1, make_result(ST_MISS, 0)},
            '{ACT_READ,  25'd0,        1, make_result(ST_HIT)},
            '{ACT_MARK,  25'd0,        1, make_result(ST_HIT)},
            '{ACT_WRITE, 25'h0AAAAAA,  0, make_result(ST_HIT)},
            '{ACT_READ,  25'h0555555,  0, make_result(ST_HIT)},
            '{ACT_FLUSH, 25'd0,        0, make_result(ST_HIT)},
            '{ACT_FLUSH, 25'd0,        1, make_result(ST_NODIRTY)},
            '{ACT_WRITE, 25'd7,        0, make_result(ST_HIT)},
            '{ACT_CLEAR, 25'd0,        0, make_result(ST_HIT)},
            '{ACT_CLEAR, 25'd0,        1, make_result(ST_NODIRTY)},
            '{ACT_READ,  25'h0FFFFFF,  1, make_result(ST_MISS, 1)}
        };
        empty_directory();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].has_result) begin
                // Wait for the queue to drain so the typed-in result is the
                // head of what the next request produces.
                sender_gap(1);
                while (pending_results.size() != 0)
                    @(negedge i_clk);
            end
            issue_request(directed[k].action, directed[k].page);
            if (directed[k].has_result && pending_results[0] !== directed[k].known_result) begin
                $display("%0t: row %0d expected %h actual prediction %h", $time, k,
                         directed[k].known_result, pending_results[0]);
                fail_count++;
            end
        end

        // Fill past capacity with writes so evictions of dirty pages occur.
        for (int k = 0; k < ENTRIES + 3; k++)
            issue_request(ACT_WRITE, 25'(k + 100));
        issue_request(ACT_FLUSH, 25'd0);

        // Random bursts with gaps; some bursts run with no idling at all.
        for (int k = 0; k < RANDOM_REQUESTS; k += burst) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++) begin
                act = random_action();
                issue_request(act, random_page());
            end
            if ($urandom_range(0, 3) != 0)
                sender_gap($urandom_range(1, 6));
            if (k % 60 == 0) begin
                // Hold off until every expected result has come.
                sender_gap(1);
                while (pending_results.size() != 0)
                    @(negedge i_clk);
            end
        end

        sender_gap(1);
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("lru_writeback_page_cache_test OK");
        else
            $display("lru_writeback_page_cache_test NOT OK");
        $finish;
    end
endmodule
